// File: hdl/v4a_pkg.sv
// Shared constants, types and helpers for the four-lane Q16.16 vector ALU.
// Depends on nothing; v4a_div and the top level refer to it by scoped names.
package v4a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_DOT   = 3'd5;
  localparam logic [2:0] OP_LEN   = 3'd6;
  localparam logic [2:0] OP_SWZ   = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN = 32'h8000_0000;

  typedef logic [3:0][31:0] vec_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  typedef struct packed {
    logic [2:0] op;
    vec_t       res;
    logic [1:0] st;
    logic       lsat;
  } rec_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic sat_t sat66(input logic signed [65:0] v);
    sat_t r;
    r.ovf = !((&v[65:31]) || !(|v[65:31]));
    r.val = r.ovf ? (v[65] ? WORD_MIN : WORD_MAX) : v[31:0];
    return r;
  endfunction

endpackage

// File: hdl/v4a_div.sv
// Pipelined restoring divider for one lane: |num| * 2^FRAC_BITS / |den|, signed result.
// One quotient bit per stage, 33 register stages. Uses v4a_pkg.
module v4a_div (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        num_mag,
  input  logic [31:0]        den_mag,
  input  logic               neg,
  output v4a_pkg::sat_t      res
);

  localparam int HI_SHIFT = 32 - v4a_pkg::FRAC_BITS;
  localparam logic [31:0] WORD_MIN_U = v4a_pkg::WORD_MIN;

  logic [31:0] rem [0:32];
  logic [31:0] nb  [0:32];
  logic [31:0] qt  [0:32];
  logic [31:0] dn  [0:32];
  logic        hi  [0:32];
  logic        ng  [0:32];

  // The quotient reaches 2^32 exactly when the high part of the numerator
  // already covers the divisor; the stages then only form the low 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      hi[0]  <= (num_mag >> HI_SHIFT) >= den_mag;
      rem[0] <= num_mag >> HI_SHIFT;
      nb[0]  <= num_mag << v4a_pkg::FRAC_BITS;
      qt[0]  <= '0;
      dn[0]  <= den_mag;
      ng[0]  <= neg;
    end
  end

  for (genvar k = 1; k <= 32; k++) begin : g_step
    logic [32:0] shifted;
    logic [33:0] diff;
    logic        ge;
    assign shifted = {rem[k-1], nb[k-1][31]};
    assign diff    = {1'b0, shifted} - {2'b00, dn[k-1]};
    assign ge      = !diff[33];
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[31:0] : shifted[31:0];
        nb[k]  <= {nb[k-1][30:0], 1'b0};
        qt[k]  <= {qt[k-1][30:0], ge};
        dn[k]  <= dn[k-1];
        hi[k]  <= hi[k-1];
        ng[k]  <= ng[k-1];
      end
    end
  end

  always_comb begin
    res.ovf = hi[32] || (!ng[32] && qt[32][31]) || (ng[32] && (qt[32] > WORD_MIN_U));
    if (res.ovf) begin
      res.val = ng[32] ? v4a_pkg::WORD_MIN : v4a_pkg::WORD_MAX;
    end else begin
      res.val = ng[32] ? (~qt[32] + 32'd1) : qt[32];
    end
  end

endmodule

// File: hdl/v4a_sqrt.sv
// Pipelined digit-by-digit integer square root of a 62-bit radicand.
// One root bit per stage, 31 register stages. Depends on nothing.
module v4a_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] radicand,
  output logic [30:0] root
);

  logic [32:0] rem  [1:31];
  logic [61:0] rest [1:31];
  logic [30:0] rt   [1:31];

  for (genvar k = 1; k <= 31; k++) begin : g_step
    logic [32:0] prem;
    logic [61:0] prest;
    logic [30:0] prt;
    logic [34:0] cur;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;
    if (k == 1) begin : g_first
      assign prem  = '0;
      assign prest = radicand;
      assign prt   = '0;
    end else begin : g_next
      assign prem  = rem[k-1];
      assign prest = rest[k-1];
      assign prt   = rt[k-1];
    end
    assign cur   = {prem, prest[61:60]};
    assign trial = {2'b00, prt, 2'b01};
    assign diff  = cur - trial;
    assign ge    = cur >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? diff[32:0] : cur[32:0];
        rest[k] <= {prest[59:0], 2'b00};
        rt[k]   <= {prt[29:0], ge};
      end
    end
  end

  assign root = rt[31];

endmodule

// File: hdl/vector4_alu_top.sv
// Top level of the four-lane Q16.16 vector ALU.
// Depends on v4a_pkg, v4a_div and v4a_sqrt.

// The block accepts one word per clock cycle while the output side does not
// stall, and returns one result word per accepted word, in order. The
// latency is set by the divide path: a setup stage and a 32-stage restoring
// divider (one quotient bit per stage) sit behind four operand and product
// stages; the square-root unit for length is 31 stages and is lined up with
// it. Every operation passes through the same pipeline, so words of
// different operations never overtake one another. When the output is held
// off, the whole pipeline freezes in place, so nothing is lost or repeated,
// and in_ready follows out_ready in the same cycle. No word is taken while
// reset is high.
module vector4_alu_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] first_z,
  input  logic signed [31:0] first_w,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_z,
  input  logic signed [31:0] second_w,
  input  logic [2:0]         swizzle_count,
  input  logic [7:0]         swizzle_selects,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_x,
  output logic signed [31:0] result_y,
  output logic signed [31:0] result_z,
  output logic signed [31:0] result_w,
  output logic [1:0]         status
);

  localparam int LAST = 37;

  // The pipeline moves only when the output register is free or being taken.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !rst;

  logic [LAST:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[LAST-1:1], in_valid};
      out_valid <= vld[LAST];
    end
  end

  // Stage 1: registered input word.
  logic [2:0]         op1;
  logic signed [31:0] a1 [4];
  logic signed [31:0] b1 [4];
  logic [2:0]         cnt1;
  logic [7:0]         sel1;

  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= operation;
      a1[0] <= first_x;
      a1[1] <= first_y;
      a1[2] <= first_z;
      a1[3] <= first_w;
      b1[0] <= second_x;
      b1[1] <= second_y;
      b1[2] <= second_z;
      b1[3] <= second_w;
      cnt1  <= swizzle_count;
      sel1  <= swizzle_selects;
    end
  end

  // Stage 2 logic: the lane-wise operations finish here; the others get
  // their multiplier operands and divider magnitudes ready.
  v4a_pkg::rec_t      rec2c;
  logic signed [31:0] ma2c [6];
  logic signed [31:0] mb2c [6];
  logic [31:0]        am2c [4];
  logic [31:0]        bm2c;
  logic [3:0]         ng2c;

  always_comb begin
    v4a_pkg::sat_t t;
    logic          ovf;
    t        = '0;
    rec2c    = '0;
    rec2c.op = op1;
    rec2c.st = v4a_pkg::ST_OK;
    ovf      = 1'b0;
    case (op1)
      v4a_pkg::OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          t = v4a_pkg::sat66(66'(a1[i]) + 66'(b1[i]));
          rec2c.res[i] = t.val;
          ovf = ovf | t.ovf;
        end
      end
      v4a_pkg::OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          t = v4a_pkg::sat66(66'(a1[i]) - 66'(b1[i]));
          rec2c.res[i] = t.val;
          ovf = ovf | t.ovf;
        end
      end
      v4a_pkg::OP_DIV: begin
        // Division by zero saturates each lane by the sign of its numerator.
        if (b1[0] == 32'sd0) begin
          for (int i = 0; i < 4; i++) begin
            if (a1[i] > 32'sd0) begin
              rec2c.res[i] = v4a_pkg::WORD_MAX;
            end else if (a1[i] < 32'sd0) begin
              rec2c.res[i] = v4a_pkg::WORD_MIN;
            end else begin
              rec2c.res[i] = '0;
            end
          end
          rec2c.st = v4a_pkg::ST_DIV0;
        end
      end
      v4a_pkg::OP_SWZ: begin
        // Counts of four or more fill all lanes; lanes at or above the count stay zero.
        for (int i = 0; i < 4; i++) begin
          if (cnt1 > 3'(i)) begin
            rec2c.res[i] = a1[sel1[2*i +: 2]];
          end
        end
      end
      default: begin
      end
    endcase
    if (ovf) begin
      rec2c.st = v4a_pkg::ST_OVF;
    end

    for (int i = 0; i < 4; i++) begin
      ma2c[i] = a1[i];
      mb2c[i] = b1[i];
    end
    ma2c[4] = '0;
    mb2c[4] = '0;
    ma2c[5] = '0;
    mb2c[5] = '0;
    case (op1)
      v4a_pkg::OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          ma2c[i] = a1[0];
        end
      end
      v4a_pkg::OP_CROSS: begin
        ma2c[0] = a1[1]; mb2c[0] = b1[2];
        ma2c[1] = a1[2]; mb2c[1] = b1[1];
        ma2c[2] = a1[2]; mb2c[2] = b1[0];
        ma2c[3] = a1[0]; mb2c[3] = b1[2];
        ma2c[4] = a1[0]; mb2c[4] = b1[1];
        ma2c[5] = a1[1]; mb2c[5] = b1[0];
      end
      v4a_pkg::OP_LEN: begin
        for (int i = 0; i < 4; i++) begin
          mb2c[i] = a1[i];
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < 4; i++) begin
      am2c[i] = a1[i][31] ? (~a1[i] + 32'd1) : a1[i];
      ng2c[i] = a1[i][31] ^ b1[0][31];
    end
    bm2c = b1[0][31] ? (~b1[0] + 32'd1) : b1[0];
  end

  // Stage 2 registers, then products in stage 3.
  v4a_pkg::rec_t      rec [2:LAST];
  logic signed [31:0] ma2 [6];
  logic signed [31:0] mb2 [6];
  logic [31:0]        am2 [4];
  logic [31:0]        am3 [4];
  logic [31:0]        am4 [4];
  logic [31:0]        bm2;
  logic [31:0]        bm3;
  logic [31:0]        bm4;
  logic [3:0]         ng2;
  logic [3:0]         ng3;
  logic [3:0]         ng4;
  logic signed [63:0] p3 [6];

  always_ff @(posedge clk) begin
    if (adv) begin
      rec[2] <= rec2c;
      ma2    <= ma2c;
      mb2    <= mb2c;
      am2    <= am2c;
      bm2    <= bm2c;
      ng2    <= ng2c;
      for (int k = 0; k < 6; k++) begin
        p3[k] <= ma2[k] * mb2[k];
      end
      am3    <= am2;
      bm3    <= bm2;
      ng3    <= ng2;
      am4    <= am3;
      bm4    <= bm3;
      ng4    <= ng3;
    end
  end

  // Stage 4: differences for cross, pair sums for dot and length.
  logic signed [64:0] x4c [4];
  logic signed [64:0] x4  [4];
  logic signed [65:0] y5c [4];
  logic signed [65:0] y5  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x4c[i] = 65'(p3[i]);
    end
    case (rec[3].op)
      v4a_pkg::OP_CROSS: begin
        x4c[0] = 65'(p3[0]) - 65'(p3[1]);
        x4c[1] = 65'(p3[2]) - 65'(p3[3]);
        x4c[2] = 65'(p3[4]) - 65'(p3[5]);
        x4c[3] = '0;
      end
      v4a_pkg::OP_DOT, v4a_pkg::OP_LEN: begin
        x4c[0] = 65'(p3[0]) + 65'(p3[1]);
        x4c[1] = 65'(p3[2]) + 65'(p3[3]);
        x4c[2] = '0;
        x4c[3] = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      y5c[i] = 66'(x4[i]);
    end
    if (rec[4].op == v4a_pkg::OP_DOT || rec[4].op == v4a_pkg::OP_LEN) begin
      y5c[0] = 66'(x4[0]) + 66'(x4[1]);
      y5c[1] = '0;
    end
  end

  // Stage 6 logic: the exact products and sums are scaled back by a floor shift and
  // clamped; the length radicand heads for the square-root unit.
  v4a_pkg::rec_t rec6c;
  logic [61:0]   sq6c;

  always_comb begin
    v4a_pkg::sat_t t;
    logic          ovf;
    t     = '0;
    rec6c = rec[5];
    ovf   = 1'b0;
    sq6c  = y5[0][61:0];
    case (rec[5].op)
      v4a_pkg::OP_SCALE, v4a_pkg::OP_CROSS, v4a_pkg::OP_DOT: begin
        for (int i = 0; i < 4; i++) begin
          t = v4a_pkg::sat66(y5[i] >>> v4a_pkg::FRAC_BITS);
          rec6c.res[i] = t.val;
          ovf = ovf | t.ovf;
        end
        rec6c.st = ovf ? v4a_pkg::ST_OVF : v4a_pkg::ST_OK;
      end
      v4a_pkg::OP_LEN: begin
        // A radicand of 2^62 or more has a root of 2^31 or more.
        rec6c.lsat = |y5[0][65:62];
      end
      default: begin
      end
    endcase
  end

  logic [61:0] sq6;

  always_ff @(posedge clk) begin
    if (adv) begin
      x4     <= x4c;
      rec[3] <= rec[2];
      rec[4] <= rec[3];
      y5     <= y5c;
      rec[5] <= rec[4];
      rec[6] <= rec6c;
      sq6    <= sq6c;
      for (int k = 7; k <= LAST; k++) begin
        rec[k] <= rec[k-1];
      end
    end
  end

  // Long-latency units, both delivering at the last pipeline stage.
  v4a_pkg::sat_t div_res [4];
  logic [30:0]   root;

  for (genvar i = 0; i < 4; i++) begin : g_div
    v4a_div u_div (
      .clk     (clk),
      .en      (adv),
      .num_mag (am4[i]),
      .den_mag (bm4),
      .neg     (ng4[i]),
      .res     (div_res[i])
    );
  end

  v4a_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (sq6),
    .root     (root)
  );

  // Final selection into the output register.
  v4a_pkg::rec_t fin;

  always_comb begin
    logic ovf;
    fin = rec[LAST];
    ovf = 1'b0;
    if (rec[LAST].op == v4a_pkg::OP_DIV && rec[LAST].st != v4a_pkg::ST_DIV0) begin
      for (int i = 0; i < 4; i++) begin
        fin.res[i] = div_res[i].val;
        ovf = ovf | div_res[i].ovf;
      end
      fin.st = ovf ? v4a_pkg::ST_OVF : v4a_pkg::ST_OK;
    end else if (rec[LAST].op == v4a_pkg::OP_LEN) begin
      fin.res[0] = rec[LAST].lsat ? v4a_pkg::WORD_MAX : {1'b0, root};
      fin.st     = rec[LAST].lsat ? v4a_pkg::ST_OVF : v4a_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_x <= fin.res[0];
      result_y <= fin.res[1];
      result_z <= fin.res[2];
      result_w <= fin.res[3];
      status   <= fin.st;
    end
  end

  // A divide-by-zero status can only come from a divide word.
  assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && rec[LAST].st == v4a_pkg::ST_DIV0 |-> rec[LAST].op == v4a_pkg::OP_DIV)
    else $error("divide-by-zero status on a non-divide word");

  // A word leaving the last stage while the pipeline moves must appear at the output.
  assert property (@(posedge clk) disable iff (rst)
    vld[LAST] && adv |=> out_valid)
    else $error("word lost at the output register");

  // The output status code is never the unused code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule
